FILE: hw/rtl/lsac_pkg.sv
// ----------------------------------------------------------------------------
// LRU set-associative cache tag model: shared package
// Sizes of the tag store, row layout, configuration register codes, the
// sequencer state type and the lookup unit's request and result structs.
// ----------------------------------------------------------------------------
package lsac_pkg;

	localparam int SETS      = 256;
	localparam int SET_BITS  = 8;
	localparam int WAYS      = 4;
	localparam int WAY_BITS  = 2;
	localparam int AGE_BITS  = 2;
	localparam int TAG_W     = 64;
	localparam int ADDR_W    = 64;
	localparam int TOTAL_W   = 48;
	localparam int LIMIT_W   = WAY_BITS + 1;

	localparam int META_W    = WAYS + WAYS * AGE_BITS;
	localparam int ROW_W     = WAYS * TAG_W + META_W;

	// Result item: hit, prefetch_done, prefetch_hit, hit_total, miss_total.
	localparam int OUT_FIELDS_W = 3 + 2 * TOTAL_W;
	localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS      = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WAYS_IN_USE     = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WRITE_ALLOCATE  = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PREFETCH_ENABLE = 8'd3;

	typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

	typedef struct packed {
		logic [WAYS-1:0]                valid;
		logic [WAYS-1:0][AGE_BITS-1:0]  age;
	} meta_t;

	typedef struct packed {
		logic                           hit;
		logic                           wr;
		logic                           alloc;
		logic [WAY_BITS-1:0]            victim;
		logic [WAYS-1:0]                valid;
		logic [WAYS-1:0][AGE_BITS-1:0]  age;
	} upd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEMAND,
		ST_PREFETCH,
		ST_EMIT
	} state_t;

endpackage

FILE: hw/rtl/lsac_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lsac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/lsac_way_unit.sv
// ----------------------------------------------------------------------------
// Set lookup and LRU update unit
// Compares a block address against one set, then promotes the hit line or
// picks the way to allocate and works out the new valid bits and ages.
// ----------------------------------------------------------------------------
module lsac_way_unit (
	input  lsac_pkg::tag_row_t                 tags,
	input  lsac_pkg::meta_t                    meta,
	input  logic [lsac_pkg::TAG_W-1:0]         blk,
	input  logic                               allocate,
	input  logic [lsac_pkg::LIMIT_W-1:0]       ways_in_use,
	output lsac_pkg::upd_t                     upd
);

	logic [lsac_pkg::WAYS-1:0]          hit_vec;
	logic                               any_hit;
	logic [lsac_pkg::WAY_BITS-1:0]      hit_way;
	logic [lsac_pkg::WAY_BITS-1:0]      free_way;
	logic [lsac_pkg::WAY_BITS-1:0]      lru_way;
	logic [lsac_pkg::WAY_BITS-1:0]      victim;
	logic [lsac_pkg::AGE_BITS-1:0]      hit_age;
	logic [lsac_pkg::AGE_BITS-1:0]      best_age;
	logic                               found;
	logic [lsac_pkg::LIMIT_W-1:0]       count;
	logic [lsac_pkg::LIMIT_W-1:0]       limit;
	logic                               full;
	logic [lsac_pkg::WAYS-1:0]          v_next;

	// Tag compare, occupancy and the candidate ways.
	always_comb begin
		hit_way  = '0;
		free_way = '0;
		count    = '0;
		for (int w = lsac_pkg::WAYS - 1; w >= 0; w--) begin
			hit_vec[w] = meta.valid[w] && (tags[w] == blk);
			if (hit_vec[w]) begin
				hit_way = lsac_pkg::WAY_BITS'(w);
			end
			if (!meta.valid[w]) begin
				free_way = lsac_pkg::WAY_BITS'(w);
			end
			count = count + {{lsac_pkg::WAY_BITS{1'b0}}, meta.valid[w]};
		end
		any_hit = |hit_vec;
		hit_age = meta.age[hit_way];

		// Oldest valid line; the lowest way wins a tie.
		found    = 1'b0;
		best_age = '0;
		lru_way  = '0;
		for (int w = 0; w < lsac_pkg::WAYS; w++) begin
			if (meta.valid[w] && (!found || meta.age[w] > best_age)) begin
				lru_way  = lsac_pkg::WAY_BITS'(w);
				best_age = meta.age[w];
				found    = 1'b1;
			end
		end

		if (ways_in_use == '0) begin
			limit = lsac_pkg::LIMIT_W'(1);
		end else if (ways_in_use > lsac_pkg::LIMIT_W'(lsac_pkg::WAYS)) begin
			limit = lsac_pkg::LIMIT_W'(lsac_pkg::WAYS);
		end else begin
			limit = ways_in_use;
		end
		full   = count >= limit;
		victim = full ? lru_way : free_way;
	end

	// New metadata for the set.
	always_comb begin
		upd        = '0;
		upd.valid  = meta.valid;
		upd.age    = meta.age;
		upd.hit    = any_hit;
		upd.victim = any_hit ? hit_way : victim;
		v_next     = meta.valid;
		if (any_hit) begin
			for (int k = 0; k < lsac_pkg::WAYS; k++) begin
				if (meta.valid[k] && meta.age[k] < hit_age) begin
					upd.age[k] = meta.age[k] + lsac_pkg::AGE_BITS'(1);
				end
			end
			upd.age[hit_way] = '0;
			upd.wr           = 1'b1;
		end else if (allocate) begin
			if (full) begin
				v_next[victim] = 1'b0;
			end
			for (int k = 0; k < lsac_pkg::WAYS; k++) begin
				if (v_next[k]) begin
					upd.age[k] = meta.age[k] + lsac_pkg::AGE_BITS'(1);
				end
			end
			v_next[victim]  = 1'b1;
			upd.age[victim] = '0;
			upd.valid       = v_next;
			upd.wr          = 1'b1;
			upd.alloc       = 1'b1;
		end
	end

endmodule

FILE: hw/rtl/lru_set_assoc_cache_tag_model_unit.sv
// ----------------------------------------------------------------------------
// LRU set-associative cache tag model: top level
// Steps: set row read, demand lookup and write-back, next-block prefetch
// lookup if made, output register load; a new transaction is taken only
// after that. The set RAM has a write and a read port; the one shared
// lookup unit handles one set per cycle. Reset is immediate: per-set valid
// flops make every set read as empty, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_tag_model_unit (
	input  logic                              clk,
	input  logic                              arst_n,

	// Access stream. tdata: address[63:0]. tuser: kind (0 load, 1 store).
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [lsac_pkg::ADDR_W-1:0]       s_axis_tdata,
	input  logic                              s_axis_tuser,

	// Result stream. tdata, from bit 0 up: hit, prefetch_done, prefetch_hit,
	// hit_total[47:0], miss_total[47:0], zero padding.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [lsac_pkg::OUT_W-1:0]        m_axis_tdata,

	// Configuration writes.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lsac_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [lsac_pkg::CFG_DATA_W-1:0]   cfg_data
);

	lsac_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [2:0]                      block_bits_q;
	logic [lsac_pkg::LIMIT_W-1:0]    ways_in_use_q;
	logic                            write_allocate_q;
	logic                            prefetch_enable_q;

	// Item context.
	logic [lsac_pkg::TAG_W-1:0]      blk_q;
	logic                            store_q;
	logic                            hit_q;
	logic                            pf_done_q;
	logic                            pf_hit_q;
	logic [lsac_pkg::TOTAL_W-1:0]    hits_q;
	logic [lsac_pkg::TOTAL_W-1:0]    misses_q;

	// One flop per set says whether the set row in RAM has ever been written.
	logic [lsac_pkg::SETS-1:0]       row_valid_q;
	logic                            rd_row_valid_q;

	// Output register.
	logic                            out_valid_q;
	logic [lsac_pkg::OUT_W-1:0]      out_data_q;

	logic [lsac_pkg::TAG_W-1:0]      in_blk;
	logic [lsac_pkg::TAG_W-1:0]      next_blk;
	logic                            in_fire;
	logic                            ram_re;
	logic [lsac_pkg::SET_BITS-1:0]   ram_raddr;
	logic                            ram_we;
	logic [lsac_pkg::ROW_W-1:0]      ram_wdata;
	logic [lsac_pkg::ROW_W-1:0]      ram_rdata;
	lsac_pkg::tag_row_t              rd_tags;
	lsac_pkg::tag_row_t              wr_tags;
	lsac_pkg::meta_t                 rd_meta;
	lsac_pkg::meta_t                 wr_meta;
	logic                            lookup_alloc;
	lsac_pkg::upd_t                  upd;
	logic                            want_pf;
	logic                            emit_load;
	logic [lsac_pkg::OUT_FIELDS_W-1:0] result_fields;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == lsac_pkg::ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Block address of the incoming access, and the next block for prefetch.
	// The next block wraps within the 64 - block_bits bits of a block address.
	assign in_blk   = s_axis_tdata >> block_bits_q;
	assign next_blk = (blk_q + lsac_pkg::TAG_W'(1)) & ({lsac_pkg::TAG_W{1'b1}} >> block_bits_q);

	// A row that was never written reads as an empty set.
	assign rd_tags = ram_rdata[lsac_pkg::WAYS*lsac_pkg::TAG_W-1:0];
	assign rd_meta = rd_row_valid_q ? lsac_pkg::meta_t'(ram_rdata[lsac_pkg::ROW_W-1 -: lsac_pkg::META_W])
	                                : '0;

	// Demand loads always allocate; stores only with write-allocate on.
	// Prefetch lookups always allocate.
	assign lookup_alloc = (state_q == lsac_pkg::ST_PREFETCH) || !store_q || write_allocate_q;
	assign want_pf      = !upd.hit && !store_q && prefetch_enable_q;

	lsac_way_unit u_way_unit (
		.tags        (rd_tags),
		.meta        (rd_meta),
		.blk         (blk_q),
		.allocate    (lookup_alloc),
		.ways_in_use (ways_in_use_q),
		.upd         (upd)
	);

	// The victim way takes the new tag; the other ways are written back as read.
	always_comb begin
		wr_tags = rd_tags;
		if (upd.alloc) begin
			wr_tags[upd.victim] = blk_q;
		end
		wr_meta.valid = upd.valid;
		wr_meta.age   = upd.age;
	end
	assign ram_wdata = {wr_meta, wr_tags};

	lsac_ram #(
		.WIDTH (lsac_pkg::ROW_W),
		.DEPTH (lsac_pkg::SETS)
	) u_set_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (blk_q[lsac_pkg::SET_BITS-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer. The demand lookup writes its set back in the same cycle in
	// which the next block's set is read; the two sets always differ, since
	// consecutive blocks fall into neighboring sets.
	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = in_blk[lsac_pkg::SET_BITS-1:0];
		ram_we    = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			lsac_pkg::ST_IDLE: begin
				if (in_fire) begin
					ram_re  = 1'b1;
					state_d = lsac_pkg::ST_DEMAND;
				end
			end
			lsac_pkg::ST_DEMAND: begin
				ram_we = upd.wr;
				if (want_pf) begin
					ram_re    = 1'b1;
					ram_raddr = next_blk[lsac_pkg::SET_BITS-1:0];
					state_d   = lsac_pkg::ST_PREFETCH;
				end else begin
					state_d = lsac_pkg::ST_EMIT;
				end
			end
			lsac_pkg::ST_PREFETCH: begin
				ram_we  = upd.wr;
				state_d = lsac_pkg::ST_EMIT;
			end
			lsac_pkg::ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					emit_load = 1'b1;
					state_d   = lsac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lsac_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bits_q      <= 3'd3;
			ways_in_use_q     <= lsac_pkg::LIMIT_W'(4);
			write_allocate_q  <= 1'b1;
			prefetch_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lsac_pkg::REG_BLOCK_BITS:      block_bits_q      <= cfg_data[2:0];
				lsac_pkg::REG_WAYS_IN_USE:     ways_in_use_q     <= cfg_data[lsac_pkg::LIMIT_W-1:0];
				lsac_pkg::REG_WRITE_ALLOCATE:  write_allocate_q  <= cfg_data[0];
				lsac_pkg::REG_PREFETCH_ENABLE: prefetch_enable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Set occupancy flags and the flag that travels with the RAM read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q    <= '0;
			rd_row_valid_q <= 1'b0;
		end else begin
			if (ram_re) begin
				rd_row_valid_q <= row_valid_q[ram_raddr];
			end
			if (ram_we) begin
				row_valid_q[blk_q[lsac_pkg::SET_BITS-1:0]] <= 1'b1;
			end
		end
	end

	// Running totals; prefetch lookups do not count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
		end else if (state_q == lsac_pkg::ST_DEMAND) begin
			if (upd.hit) begin
				if (hits_q != {lsac_pkg::TOTAL_W{1'b1}}) begin
					hits_q <= hits_q + lsac_pkg::TOTAL_W'(1);
				end
			end else begin
				if (misses_q != {lsac_pkg::TOTAL_W{1'b1}}) begin
					misses_q <= misses_q + lsac_pkg::TOTAL_W'(1);
				end
			end
		end
	end

	// Item context: block address (replaced by the next block for the
	// prefetch lookup) and the result flags.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			blk_q     <= in_blk;
			store_q   <= s_axis_tuser;
			pf_done_q <= 1'b0;
			pf_hit_q  <= 1'b0;
		end else if (state_q == lsac_pkg::ST_DEMAND) begin
			hit_q <= upd.hit;
			if (want_pf) begin
				blk_q     <= next_blk;
				pf_done_q <= 1'b1;
			end
		end else if (state_q == lsac_pkg::ST_PREFETCH) begin
			pf_hit_q <= upd.hit;
		end
	end

	// Output register: the next access can be accepted while a result waits.
	assign result_fields = {misses_q, hits_q, pf_hit_q, pf_done_q, hit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_data_q <= lsac_pkg::OUT_W'(result_fields);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
